[src/word_xorshift_string_hash_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the word xorshift string hash
// Each macro assumes a clock named clk in scope; the first two also need a reset named rst.
// ----------------------------------------------------------------------------
`ifndef WORD_XORSHIFT_STRING_HASH_ASSERT_SVH
`define WORD_XORSHIFT_STRING_HASH_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define WXSH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high
`define WXSH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs during reset
`define WXSH_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wxsh_pkg.sv]
// ----------------------------------------------------------------------------
// wxsh_pkg
// Widths, seed and mixing functions shared by the string hash modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wxsh_pkg;

  localparam int WORD_W  = 64;
  localparam int HASH_W  = 32;
  localparam int BYTES   = WORD_W / 8;

  localparam logic [WORD_W-1:0] HASH_SEED = 64'h0000_0000_F39A_5EB6;
  localparam logic [HASH_W-1:0] MASK_RESET = 32'hFFFF_FFFF;

  // Control that travels with the word in the input register
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // True if any byte of the word is zero
  function automatic logic has_zero_byte(input logic [WORD_W-1:0] w);
    logic found;
    found = 1'b0;
    for (int k = 0; k < BYTES; k++) begin
      if (w[8*k +: 8] == 8'h00) found = 1'b1;
    end
    return found;
  endfunction

  // Keep bytes up to and including the first zero byte; clear those above
  function automatic logic [WORD_W-1:0] trim_tail(input logic [WORD_W-1:0] w);
    logic              seen;
    logic [WORD_W-1:0] t;
    seen = 1'b0;
    t    = '0;
    for (int k = 0; k < BYTES; k++) begin
      t[8*k +: 8] = seen ? 8'h00 : w[8*k +: 8];
      if (w[8*k +: 8] == 8'h00) seen = 1'b1;
    end
    return t;
  endfunction

  // Fold a word with no zero byte into the running sum
  function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] s_in,
                                                  input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] s;
    s = s_in ^ w ^ (w << 12);
    s = (s << 3) ^ (s >> 5);
    s = (s << 7) ^ (s >> 13);
    s = (s >> 17) ^ (s << 23);
    return s;
  endfunction

  // Final mixing with the terminating word, low half of the result
  function automatic logic [HASH_W-1:0] finish_word(input logic [WORD_W-1:0] s_in,
                                                    input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] s;
    s = s_in ^ trim_tail(w) ^ (s_in >> 3);
    s = (s >> 7) ^ (s << 9);
    s = (s >> 13) ^ (s << 17);
    s = (s >> 31) ^ (s >> 45);
    return s[HASH_W-1:0];
  endfunction

endpackage

`default_nettype wire

[src/wxsh_ifs.sv]
// ----------------------------------------------------------------------------
// wxsh channel interfaces
// Valid/ready channels for string words, hash results and the mask write.
// ----------------------------------------------------------------------------
`default_nettype none

interface wxsh_word_if import wxsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] text_word;

  modport source (output valid, output text_word, input ready);
  modport sink   (input valid, input text_word, output ready);
endinterface

interface wxsh_hash_if import wxsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

interface wxsh_cfg_if import wxsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_mask;

  modport source (output valid, output hash_mask, input ready);
  modport sink   (input valid, input hash_mask, output ready);
endinterface

`default_nettype wire

[src/wxsh_in_stage.sv]
// ----------------------------------------------------------------------------
// wxsh_in_stage
// Input register: captures one word per transfer and flags the string end.
// ----------------------------------------------------------------------------
`default_nettype none

module wxsh_in_stage import wxsh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  wxsh_word_if.sink        text_in,
  input  wire logic        advance,
  output stage_ctl_t       ctl,
  output logic [WORD_W-1:0] word
);

  logic take;

  // Accept whenever the register is empty or moves on this cycle
  assign text_in.ready = !ctl.valid || advance;
  assign take          = text_in.valid && text_in.ready;

  // Hold the control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (take) begin
      ctl.valid <= 1'b1;
      ctl.last  <= has_zero_byte(text_in.text_word);
    end else if (advance) begin
      ctl.valid <= 1'b0;
    end
  end

  // Capture the word itself
  always_ff @(posedge clk) begin
    if (take) begin
      word <= text_in.text_word;
    end
  end

endmodule

`default_nettype wire

[src/wxsh_core.sv]
// ----------------------------------------------------------------------------
// wxsh_core
// Running sum, mask register and the per-word fold or final mix.
// ----------------------------------------------------------------------------
`default_nettype none

module wxsh_core import wxsh_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  wxsh_cfg_if.sink          cfg,
  input  wire stage_ctl_t   ctl,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic         out_free,
  output logic              advance,
  output logic              result_load,
  output logic [HASH_W-1:0] result_hash
);

  logic [WORD_W-1:0] running_sum;
  logic [WORD_W-1:0] running_sum_next;
  logic [HASH_W-1:0] hash_mask;

  // A terminating word waits for room in the result register
  assign advance     = ctl.valid && (!ctl.last || out_free);
  assign result_load = advance && ctl.last;
  assign result_hash = finish_word(running_sum, word) & hash_mask;

  assign cfg.ready = 1'b1;

  // Fold, or return to the seed at the string end
  always_comb begin
    running_sum_next = running_sum;
    if (advance) begin
      running_sum_next = ctl.last ? HASH_SEED : fold_word(running_sum, word);
    end
  end

  // Advance the running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= HASH_SEED;
    end else begin
      running_sum <= running_sum_next;
    end
  end

  // Take mask writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mask <= MASK_RESET;
    end else if (cfg.valid && cfg.ready) begin
      hash_mask <= cfg.hash_mask;
    end
  end

endmodule

`default_nettype wire

[src/wxsh_out_stage.sv]
// ----------------------------------------------------------------------------
// wxsh_out_stage
// Result register: holds one hash until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wxsh_out_stage import wxsh_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [HASH_W-1:0] hash_in,
  output logic                   out_free,
  wxsh_hash_if.source            hash_out
);

  logic              valid;
  logic [HASH_W-1:0] hash_value;

  assign out_free            = !valid || hash_out.ready;
  assign hash_out.valid      = valid;
  assign hash_out.hash_value = hash_value;

  // Hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (hash_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hash_value <= hash_in;
    end
  end

endmodule

`default_nettype wire

[src/word_xorshift_string_hash.sv]
// ----------------------------------------------------------------------------
// word_xorshift_string_hash
// Hashes NUL-terminated strings delivered as little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Channels: text_in takes one 64-bit word per transfer, first byte in bits
// 7:0. A word with no zero byte is folded into the running sum and gives no
// result. The first word holding a zero byte ends the string and gives one
// hash_value on hash_out, the low 32 bits of the mixed sum ANDed with the
// mask; the sum then returns to its seed. cfg writes the mask; write it only
// while no string is in flight.
// Flow: a terminating word passes from the input register to the result
// register, waiting in the input register while that one is full.
// Throughput: one word per cycle while no terminating word waits, set by
// the single fold of the running sum.
// Reset (rst, synchronous): empties both registers, loads the seed and sets
// the mask to all ones. When the receiver stalls, the result holds and words
// without a zero byte still flow; a terminating word waits in the input
// register, and text_in.ready drops until the held result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module word_xorshift_string_hash import wxsh_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  wxsh_word_if.sink    text_in,
  wxsh_hash_if.source  hash_out,
  wxsh_cfg_if.sink     cfg
);

  stage_ctl_t        ctl;
  logic [WORD_W-1:0] word;
  logic              advance;
  logic              out_free;
  logic              result_load;
  logic [HASH_W-1:0] result_hash;

  wxsh_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .advance (advance),
    .ctl     (ctl),
    .word    (word)
  );

  wxsh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .ctl         (ctl),
    .word        (word),
    .out_free    (out_free),
    .advance     (advance),
    .result_load (result_load),
    .result_hash (result_hash)
  );

  wxsh_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (result_load),
    .hash_in  (result_hash),
    .out_free (out_free),
    .hash_out (hash_out)
  );

endmodule

`default_nettype wire

[src/wxsh_checker.sv]
// ----------------------------------------------------------------------------
// wxsh_checker
// Port-level checks on the string hash, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "word_xorshift_string_hash_assert.svh"

module wxsh_checker import wxsh_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [HASH_W-1:0] hash_value,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready,
  input wire logic [HASH_W-1:0] cfg_mask
);

  logic [HASH_W-1:0] mask_seen;

  // Track the last mask written
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_seen <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask_seen <= cfg_mask;
    end
  end

  `WXSH_ASSERT_NXT_RST(a_reset_clears_out, rst, !out_valid, "result valid after reset")
  `WXSH_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(hash_value), "stalled result changed")
  `WXSH_ASSERT_IMP(a_masked, out_valid, (hash_value & ~mask_seen) == '0, "hash has bits outside the mask")
  `WXSH_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output back-pressure")

endmodule

bind word_xorshift_string_hash wxsh_checker u_wxsh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (text_in.ready),
  .out_valid  (hash_out.valid),
  .out_ready  (hash_out.ready),
  .hash_value (hash_out.hash_value),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .cfg_mask   (cfg.hash_mask)
);

`default_nettype wire

[bench/wxsh_hash_checker.sv]
// ----------------------------------------------------------------------------
// wxsh_hash_checker
// Watches the word, hash and mask channels of the string hash. It keeps its
// own running sum and mask, and works out the hash of each completed string.
// It then compares every hash that is taken from the block against the
// oldest hash still due.
// ----------------------------------------------------------------------------
`default_nettype none

module wxsh_hash_checker import wxsh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  wxsh_word_if  text_ch,
  wxsh_hash_if  hash_ch,
  wxsh_cfg_if   cfg_ch,
  output int    mismatches,
  output int    hashes_due
);

  localparam logic [WORD_W-1:0] LOW_BIT_PER_BYTE  = {BYTES{8'h01}};
  localparam logic [WORD_W-1:0] HIGH_BIT_PER_BYTE = {BYTES{8'h80}};
  localparam int                REPORT_LIMIT      = 10;

  logic [WORD_W-1:0] string_sum;
  logic [HASH_W-1:0] table_mask;
  logic [HASH_W-1:0] oldest_hash;
  logic [HASH_W-1:0] due_hashes[$];

  initial mismatches = 0;
  initial hashes_due = 0;

  // Borrow trick: a high bit survives only where some byte was zero
  function automatic logic ends_string(input logic [WORD_W-1:0] w);
    return ((w - LOW_BIT_PER_BYTE) & ~w & HIGH_BIT_PER_BYTE) != '0;
  endfunction

  // Clear every byte above the lowest zero byte
  function automatic logic [WORD_W-1:0] clip_after_nul(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] keep;
    keep = {WORD_W{1'b1}};
    for (int k = BYTES - 1; k >= 0; k--) begin
      if (w[8*k +: 8] == 8'h00) keep = {WORD_W{1'b1}} >> (8 * (BYTES - 1 - k));
    end
    return w & keep;
  endfunction

  // Fold one body word into the sum
  function automatic logic [WORD_W-1:0] absorb_word(input logic [WORD_W-1:0] s,
                                                    input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] a;
    a = s ^ w ^ (w << 12);
    a = (a << 3) ^ (a >> 5);
    a = (a << 7) ^ (a >> 13);
    a = (a >> 17) ^ (a << 23);
    return a;
  endfunction

  // Mix in the terminating word and mask the low half
  function automatic logic [HASH_W-1:0] close_string(input logic [WORD_W-1:0] s,
                                                     input logic [WORD_W-1:0] w,
                                                     input logic [HASH_W-1:0] m);
    logic [WORD_W-1:0] a;
    a = s ^ clip_after_nul(w) ^ (s >> 3);
    a = (a >> 7) ^ (a << 9);
    a = (a >> 13) ^ (a << 17);
    a = (a >> 31) ^ (a >> 45);
    return a[HASH_W-1:0] & m;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      string_sum <= HASH_SEED;
      table_mask <= MASK_RESET;
      due_hashes.delete();
    end else begin
      // Compare a taken hash against the oldest one due
      if (hash_ch.valid && hash_ch.ready) begin
        if (due_hashes.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("hash 0x%08h taken with none due", hash_ch.hash_value);
          mismatches <= mismatches + 1;
        end else begin
          oldest_hash = due_hashes.pop_front();
          if (hash_ch.hash_value !== oldest_hash) begin
            if (mismatches < REPORT_LIMIT)
              $display("hash_value mismatch: expected 0x%08h, got 0x%08h",
                       oldest_hash, hash_ch.hash_value);
            mismatches <= mismatches + 1;
          end
        end
      end

      // Track the mask
      if (cfg_ch.valid && cfg_ch.ready) table_mask <= cfg_ch.hash_mask;

      // Advance the sum, or close the string and queue its hash
      if (text_ch.valid && text_ch.ready) begin
        if (ends_string(text_ch.text_word)) begin
          due_hashes.push_back(close_string(string_sum, text_ch.text_word, table_mask));
          string_sum <= HASH_SEED;
        end else begin
          string_sum <= absorb_word(string_sum, text_ch.text_word);
        end
      end
    end
    hashes_due <= due_hashes.size();
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives strings of 64-bit words into the string hash with random gaps on
// both channels. It steps the mask through several settings between phases,
// and holds the hash channel off once so that the block fills up. The
// checker beside the block counts the mismatches, and this module gives the
// verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import wxsh_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_WORDS   = 270;
  localparam int PHASES        = 5;
  localparam int BURST_WORDS   = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int idle_cycles = 0;
  int words_sent  = 0;
  int mismatches;
  int hashes_due;
  bit gaps_on      = 1'b1;
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  wxsh_word_if text_ch ();
  wxsh_hash_if hash_ch ();
  wxsh_cfg_if  cfg_ch ();

  word_xorshift_string_hash DUT (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_ch),
    .hash_out (hash_ch),
    .cfg      (cfg_ch)
  );

  wxsh_hash_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .text_ch    (text_ch),
    .hash_ch    (hash_ch),
    .cfg_ch     (cfg_ch),
    .mismatches (mismatches),
    .hashes_due (hashes_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nonzero_byte();
    case ($urandom_range(0, 9))
      0:       return 8'hFF;
      1:       return 8'h01;
      2:       return 8'h80;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Word with no zero byte
  function automatic logic [WORD_W-1:0] body_word();
    logic [WORD_W-1:0] w;
    for (int k = 0; k < BYTES; k++) w[8*k +: 8] = nonzero_byte();
    return w;
  endfunction

  // Word whose lowest zero byte sits at a random place, anything above it
  function automatic logic [WORD_W-1:0] end_word();
    logic [WORD_W-1:0] w;
    int                nul_at;
    nul_at = $urandom_range(0, BYTES - 1);
    for (int k = 0; k < BYTES; k++) begin
      if (k < nul_at)       w[8*k +: 8] = nonzero_byte();
      else if (k == nul_at) w[8*k +: 8] = 8'h00;
      else                  w[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // Hold valid over back-to-back transfers, drop it only for a gap
  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_word <= w;
    do @(posedge clk); while (!text_ch.ready);
    words_sent++;
  endtask

  // Mostly short strings, a few long ones, some stray words
  task automatic send_string();
    int r;
    int body_len;
    r = $urandom_range(0, 99);
    if (r < 7) begin
      send_word({$urandom, $urandom});
      return;
    end
    body_len = (r < 90) ? $urandom_range(0, 4) : $urandom_range(5, 40);
    repeat (body_len) send_word(body_word());
    send_word(end_word());
  endtask

  // Wait until every hash due has been taken and the pipeline has emptied
  task automatic settle_block();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (hashes_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [HASH_W-1:0] m);
    settle_block();
    cfg_ch.valid     <= 1'b1;
    cfg_ch.hash_mask <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Count cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (hash_ch.valid && hash_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hash receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    hash_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_active) begin
        hold_active = 1'b1;
        hash_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        hash_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          hash_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Word sender, mask writes and verdict
  initial begin
    logic [WORD_W-1:0] corner_words [16];
    logic [HASH_W-1:0] phase_masks [PHASES];
    int                phase_end;

    text_ch.valid     <= 1'b0;
    text_ch.text_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.hash_mask  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset mask: empty strings, a zero in each
    // byte lane, several zeros in one word, and body words near the borrow
    // boundaries
    corner_words = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FF00,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF,
                     64'h0101_0101_0101_0101, 64'h8080_8080_8080_8080,
                     64'h7F7F_7F7F_7F7F_7F7F, 64'h0000_0000_0000_0001,
                     64'hFF00_FF00_FF00_FF41, 64'hAABB_CCDD_EE00_1234,
                     64'h0102_0304_0005_0607, 64'h8899_AA00_BBCC_DDEE,
                     64'h1234_0056_789A_BCDE, 64'h7F00_FFFF_FFFF_FFFF,
                     64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_0000};
    foreach (corner_words[i]) send_word(corner_words[i]);

    phase_masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, $urandom,
                    32'h8000_0001};
    for (int p = 0; p < PHASES; p++) begin
      write_mask(phase_masks[p]);
      gaps_on = (p != 3);

      // Hold the hash channel off while terminating words keep coming
      if (p == 1) begin
        hold_request = 1'b1;
        while (!hold_active) @(posedge clk);
        gaps_on = 1'b0;
        repeat (BURST_WORDS) send_word(end_word());
        gaps_on = 1'b1;
      end

      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) send_string();
    end
    gaps_on = 1'b1;

    settle_block();
    if (mismatches == 0 && hashes_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
